/* rtl/memory_mapped_keyboard_display_io_core_assert.svh */
// Assertion macros for the keyboard and display bus front.
// Each check is sampled on the rising edge of clk and is held off while arst_n is low.
`ifndef MEMORY_MAPPED_KEYBOARD_DISPLAY_IO_CORE_ASSERT_SVH
`define MEMORY_MAPPED_KEYBOARD_DISPLAY_IO_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MMKD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmkd same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define MMKD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmkd next-cycle check failed");

`endif

/* rtl/mmkd_pkg.sv */
package mmkd_pkg;

	// Line length and main memory size
	localparam int unsigned LINE_WIDTH = 40;
	localparam int unsigned MEM_DEPTH  = 65536;
	localparam int unsigned MEM_AW     = $clog2(MEM_DEPTH);
	localparam int unsigned COL_W      = 6;

	// I/O page and register offsets
	localparam logic [7:0] IO_PAGE  = 8'hD0;
	localparam logic [7:0] IO_KBD   = 8'h10;
	localparam logic [7:0] IO_KBDCR = 8'h11;
	localparam logic [7:0] IO_DSP   = 8'h12;
	localparam logic [7:0] IO_DSPCR = 8'h13;

	// Character codes
	localparam logic [6:0] CH_LAST_CTRL = 7'h1F;
	localparam logic [6:0] CH_BS        = 7'h08;
	localparam logic [6:0] CH_CR        = 7'h0D;
	localparam logic [7:0] FLAG_BIT     = 8'h80;
	localparam logic [7:0] LOW_SEVEN    = 8'h7F;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_EXEC = 1'b1
	} state_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic execute;
	} ctrl_t;

endpackage

/* rtl/memory_mapped_keyboard_display_io_core.sv */
// Channel   Handshake             Ports
// command   start, busy           cmd, addr_high, addr_low, write_data, key_ready, key_code
// result    done (one cycle)      read_data, print_valid, print_char, print_newline
//
// Each word passes through the capture edge, which also issues the memory
// read, and an execute cycle; done is high in the cycle after execute.
// A new word may be accepted as soon as busy falls, while done shows.
// Reset clears the I/O registers and the column counter; main memory is not cleared.
// The receiver cannot stall, so results never wait.
`include "memory_mapped_keyboard_display_io_core_assert.svh"

module memory_mapped_keyboard_display_io_core
	import mmkd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] cmd,
	input  logic [7:0] addr_high,
	input  logic [7:0] addr_low,
	input  logic [7:0] write_data,
	input  logic       key_ready,
	input  logic [7:0] key_code,
	output logic       done,
	output logic [7:0] read_data,
	output logic       print_valid,
	output logic [6:0] print_char,
	output logic       print_newline
);

	ctrl_t ctrl;

	// Sequencer.
	mmkd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// Registers, memory and display logic.
	mmkd_datapath u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.cmd           (cmd),
		.addr_high     (addr_high),
		.addr_low      (addr_low),
		.write_data    (write_data),
		.key_ready     (key_ready),
		.key_code      (key_code),
		.done          (done),
		.read_data     (read_data),
		.print_valid   (print_valid),
		.print_char    (print_char),
		.print_newline (print_newline)
	);

	// The execute cycle lasts exactly one cycle and its result follows it.
	`MMKD_ASSERT_NEXT(a_exec_one_cycle, busy, !busy && done)
	// An accepted word always enters execute.
	`MMKD_ASSERT_NEXT(a_accept_exec, start && !busy, busy)
	// A line break is only reported together with a character.
	`MMKD_ASSERT_NOW(a_newline_char, done && print_newline, print_valid)
	// A printed character never comes with read data.
	`MMKD_ASSERT_NOW(a_print_no_read, done && print_valid, read_data == 8'h00)

endmodule

/* rtl/mmkd_ram.sv */
module mmkd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port, registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/mmkd_ctrl.sv */
module mmkd_ctrl
	import mmkd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  start,
	output logic  busy,
	output ctrl_t ctrl
);

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state: a word is captured, then executed in the following cycle.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Outputs to the datapath and the handshake.
	always_comb begin
		ctrl.capture = 1'b0;
		ctrl.execute = 1'b0;
		busy         = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				ctrl.capture = start;
			end
			ST_EXEC: begin
				ctrl.execute = 1'b1;
				busy         = 1'b1;
			end
			default: begin
				busy = 1'b0;
			end
		endcase
	end

endmodule

/* rtl/mmkd_datapath.sv */
module mmkd_datapath
	import mmkd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  ctrl_t      ctrl,
	input  logic [1:0] cmd,
	input  logic [7:0] addr_high,
	input  logic [7:0] addr_low,
	input  logic [7:0] write_data,
	input  logic       key_ready,
	input  logic [7:0] key_code,
	output logic       done,
	output logic [7:0] read_data,
	output logic       print_valid,
	output logic [6:0] print_char,
	output logic       print_newline
);

	// Captured input word
	cmd_t       cmd_q;
	logic [7:0] addr_hi_q;
	logic [7:0] addr_lo_q;
	logic [7:0] wdata_q;
	logic       key_ready_q;
	logic [7:0] key_code_q;

	// Architectural registers
	logic [7:0]       key_data_q;
	logic [7:0]       key_ctrl_q;
	logic [7:0]       dsp_data_q;
	logic [7:0]       dsp_ctrl_q;
	logic [COL_W-1:0] col_q;

	// Result registers
	logic       done_q;
	logic [7:0] rd_q;
	logic       pv_q;
	logic [6:0] pc_q;
	logic       nl_q;

	// Next values
	logic [7:0]       key_data_d;
	logic [7:0]       key_ctrl_d;
	logic [7:0]       dsp_data_d;
	logic [7:0]       dsp_ctrl_d;
	logic [COL_W-1:0] col_d;
	logic [COL_W-1:0] col_inc;
	logic [7:0]       rd_d;
	logic             pv_d;
	logic [6:0]       pc_d;
	logic             nl_d;
	logic             io_sel;
	logic [6:0]       ch;
	logic             ram_we;
	logic             ram_re;
	logic [MEM_AW-1:0] ram_addr;
	logic [7:0]       ram_rdata;
	logic [15:0]      in_addr;
	logic [15:0]      held_addr;

	// Memory is read at capture with the live address, written at execute.
	assign in_addr   = {addr_high, addr_low};
	assign held_addr = {addr_hi_q, addr_lo_q};
	assign ram_re    = ctrl.capture && (cmd_t'(cmd) == CMD_READ);
	assign ram_addr  = ctrl.execute ? held_addr[MEM_AW-1:0] : in_addr[MEM_AW-1:0];

	mmkd_ram #(
		.WIDTH (8),
		.DEPTH (MEM_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.re    (ram_re),
		.addr  (ram_addr),
		.wdata (wdata_q),
		.rdata (ram_rdata)
	);

	// Capture the input word when it is accepted.
	always_ff @(posedge clk) begin
		if (ctrl.capture) begin
			cmd_q       <= cmd_t'(cmd);
			addr_hi_q   <= addr_high;
			addr_lo_q   <= addr_low;
			wdata_q     <= write_data;
			key_ready_q <= key_ready;
			key_code_q  <= key_code;
		end
	end

	assign io_sel = (addr_hi_q == IO_PAGE) && (addr_lo_q[7:2] == IO_KBD[7:2]);
	assign ch      = dsp_data_q[6:0];
	assign col_inc = col_q + COL_W'(1);

	// Execute one bus access or tick.
	always_comb begin
		key_data_d = key_data_q;
		key_ctrl_d = key_ctrl_q;
		dsp_data_d = dsp_data_q;
		dsp_ctrl_d = dsp_ctrl_q;
		col_d      = col_q;
		rd_d       = 8'h00;
		pv_d       = 1'b0;
		pc_d       = 7'h00;
		nl_d       = 1'b0;
		ram_we     = 1'b0;
		case (cmd_q)
			CMD_WRITE: begin
				if (io_sel) begin
					unique case (addr_lo_q)
						IO_KBD:   key_data_d = wdata_q;
						IO_KBDCR: key_ctrl_d = wdata_q;
						IO_DSP:   dsp_data_d = wdata_q | FLAG_BIT;
						IO_DSPCR: dsp_ctrl_d = wdata_q;
						default:  dsp_ctrl_d = dsp_ctrl_q;
					endcase
				end else begin
					ram_we = ctrl.execute;
				end
			end
			CMD_READ: begin
				if (io_sel) begin
					unique case (addr_lo_q)
						IO_KBD: begin
							rd_d       = key_data_q;
							key_ctrl_d = key_ctrl_q & LOW_SEVEN;
						end
						IO_KBDCR: rd_d = key_ctrl_q;
						IO_DSP:   rd_d = dsp_data_q;
						IO_DSPCR: rd_d = dsp_ctrl_q;
						default:  rd_d = 8'h00;
					endcase
				end else begin
					rd_d = ram_rdata;
				end
			end
			CMD_TICK: begin
				// Keyboard: latch only when the previous key has been read.
				if (key_ready_q && !key_ctrl_q[7]) begin
					key_data_d = key_code_q | FLAG_BIT;
					key_ctrl_d = key_ctrl_q | FLAG_BIT;
				end
				// Display: a pending byte prints if it is a printable or known control code.
				if (dsp_data_q[7]) begin
					if ((ch > CH_LAST_CTRL) || (ch == CH_BS) || (ch == CH_CR)) begin
						pv_d  = 1'b1;
						pc_d  = ch;
						col_d = col_inc;
						if (ch == CH_CR) begin
							col_d = '0;
							nl_d  = 1'b1;
						end
					end
					dsp_data_d = ~dsp_data_q;
					if (col_d >= COL_W'(LINE_WIDTH)) begin
						col_d = '0;
						nl_d  = 1'b1;
					end
				end
			end
			default: begin
				rd_d = 8'h00;
			end
		endcase
	end

	// Architectural registers update at execute.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_data_q <= '0;
			key_ctrl_q <= '0;
			dsp_data_q <= '0;
			dsp_ctrl_q <= '0;
			col_q      <= '0;
			done_q     <= 1'b0;
		end else begin
			done_q <= ctrl.execute;
			if (ctrl.execute) begin
				key_data_q <= key_data_d;
				key_ctrl_q <= key_ctrl_d;
				dsp_data_q <= dsp_data_d;
				dsp_ctrl_q <= dsp_ctrl_d;
				col_q      <= col_d;
			end
		end
	end

	// Result word register.
	always_ff @(posedge clk) begin
		if (ctrl.execute) begin
			rd_q <= rd_d;
			pv_q <= pv_d;
			pc_q <= pc_d;
			nl_q <= nl_d;
		end
	end

	assign done          = done_q;
	assign read_data     = rd_q;
	assign print_valid   = pv_q;
	assign print_char    = pc_q;
	assign print_newline = nl_q;

endmodule
